### rtl/free_extent_coalescing_list_top_assert.svh
// ----------------------------------------------------------------------------
// free_extent_coalescing_list_top_assert
// assertion macros for the free extent list rtl
// ----------------------------------------------------------------------------
`ifndef FREE_EXTENT_COALESCING_LIST_TOP_ASSERT_SVH
`define FREE_EXTENT_COALESCING_LIST_TOP_ASSERT_SVH

// same-cycle implication, needs clk and rst_n in scope
`define FECL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fecl: same-cycle check failed");

// next-cycle implication, needs clk and rst_n in scope
`define FECL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fecl: next-cycle check failed");

`endif

### rtl/fecl_pkg.sv
// ----------------------------------------------------------------------------
// fecl_pkg
// shared constants and types of the free extent list
// ----------------------------------------------------------------------------
`default_nettype none

package fecl_pkg;

    localparam int DEPTH         = 256;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int START_W       = 32;
    localparam int SIZE_W        = 8;

    // fixed widths of the stream fields
    localparam int OP_W          = 2;
    localparam int START_FIELD_W = 32;
    localparam int SIZE_FIELD_W  = 8;
    localparam int SLOT_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 8;
    localparam int ENTRY_CNT_W   = 9;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 24;

    localparam int SUM_W = ((START_W > SIZE_W) ? START_W : SIZE_W) + 1;
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SIZE_OVF = 2'd3;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [SIZE_W-1:0]  size;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } ram_req_t;

    // status lands in the lowest bits when packed into tdata
    typedef struct packed {
        logic                   merged_prev;
        logic                   merged_next;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic [POS_W-1:0]       position;
        logic [STATUS_W-1:0]    status;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

### rtl/fecl_ram.sv
// ----------------------------------------------------------------------------
// fecl_ram
// extent table storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fecl_ram (
    input  wire logic              clk,
    input  wire fecl_pkg::ram_req_t req,
    output fecl_pkg::entry_t       rd_data
);

    fecl_pkg::entry_t mem [fecl_pkg::DEPTH];
    fecl_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/fecl_ctrl.sv
// ----------------------------------------------------------------------------
// fecl_ctrl
// sequencer for insert, merge, update and remove over the extent table
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_extent_coalescing_list_top_assert.svh"

module fecl_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [fecl_pkg::OP_W-1:0]           in_op,
    input  wire logic [fecl_pkg::START_FIELD_W-1:0]  in_start,
    input  wire logic [fecl_pkg::SIZE_FIELD_W-1:0]   in_size,
    input  wire logic [fecl_pkg::SLOT_W-1:0]         in_slot,
    output fecl_pkg::ram_req_t                       ram_req,
    input  wire fecl_pkg::entry_t                    ram_rd_data,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output fecl_pkg::res_t                           res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_MERGE = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                              state_reg,     state_next;
    logic [fecl_pkg::CNT_W-1:0]          count_reg,     count_next;
    logic [fecl_pkg::CNT_W-1:0]          cnt_fin_reg,   cnt_fin_next;
    logic [fecl_pkg::START_W-1:0]        nstart_reg,    nstart_next;
    logic [fecl_pkg::SIZE_W-1:0]         nsize_reg,     nsize_next;
    logic [fecl_pkg::ADDR_W-1:0]         issue_idx_reg, issue_idx_next;
    logic                                issue_more_reg, issue_more_next;
    logic                                rd_valid_reg,  rd_valid_next;
    logic [fecl_pkg::ADDR_W-1:0]         rd_idx_reg,    rd_idx_next;
    logic [fecl_pkg::ADDR_W-1:0]         pos_reg,       pos_next;
    fecl_pkg::entry_t                    next_ent_reg,  next_ent_next;
    logic                                next_vld_reg,  next_vld_next;
    fecl_pkg::entry_t                    prev_ent_reg,  prev_ent_next;
    logic                                prev_vld_reg,  prev_vld_next;
    logic [fecl_pkg::CNT_W-1:0]          sh_src_reg,    sh_src_next;
    logic [fecl_pkg::CNT_W-1:0]          sh_end_reg,    sh_end_next;
    logic [1:0]                          sh_dist_reg,   sh_dist_next;
    logic                                sh_pipe_reg,   sh_pipe_next;
    logic [fecl_pkg::ADDR_W-1:0]         sh_dst_reg,    sh_dst_next;
    logic [fecl_pkg::STATUS_W-1:0]       status_reg,    status_next;
    logic [fecl_pkg::ADDR_W-1:0]         res_pos_reg,   res_pos_next;
    logic                                mn_reg,        mn_next;
    logic                                mp_reg,        mp_next;

    logic                                in_fire;
    logic                                slot_ok;
    logic [fecl_pkg::SUM_W-1:0]          end_new;
    logic [fecl_pkg::SUM_W-1:0]          end_prev;
    logic                                touch_next;
    logic                                touch_prev;
    logic [fecl_pkg::SIZE_W:0]           sum_n;
    logic [fecl_pkg::SIZE_W:0]           sum_p;
    logic [fecl_pkg::SIZE_W-1:0]         cur_size;
    logic                                mn;
    logic                                mp;
    logic [1:0]                          drop_n;
    logic [fecl_pkg::CNT_W-1:0]          count_plus;
    logic [fecl_pkg::CNT_W-1:0]          merge_src;
    logic                                sh_issue;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign slot_ok  = fecl_pkg::CMP_W'(in_slot) < fecl_pkg::CMP_W'(count_reg);

    // touching tests, exact with one spare bit
    assign end_new    = fecl_pkg::SUM_W'(nstart_reg) + fecl_pkg::SUM_W'(nsize_reg);
    assign end_prev   = fecl_pkg::SUM_W'(prev_ent_reg.start)
                      + fecl_pkg::SUM_W'(prev_ent_reg.size);
    assign touch_next = next_vld_reg && (fecl_pkg::SUM_W'(next_ent_reg.start) == end_new);
    assign touch_prev = prev_vld_reg && (end_prev == fecl_pkg::SUM_W'(nstart_reg));

    assign sum_n    = {1'b0, nsize_reg} + {1'b0, next_ent_reg.size};
    assign mn       = touch_next && !sum_n[fecl_pkg::SIZE_W];
    assign cur_size = mn ? sum_n[fecl_pkg::SIZE_W-1:0] : nsize_reg;
    assign sum_p    = {1'b0, prev_ent_reg.size} + {1'b0, cur_size};
    assign mp       = touch_prev && !sum_p[fecl_pkg::SIZE_W];
    assign drop_n   = {1'b0, mn} + {1'b0, mp};

    assign count_plus = count_reg + fecl_pkg::CNT_W'(1);
    assign merge_src  = fecl_pkg::CNT_W'(pos_reg) + fecl_pkg::CNT_W'(1)
                      + fecl_pkg::CNT_W'(mn);
    assign sh_issue   = sh_src_reg < sh_end_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cnt_fin_next    = cnt_fin_reg;
        nstart_next     = nstart_reg;
        nsize_next      = nsize_reg;
        issue_idx_next  = issue_idx_reg;
        issue_more_next = issue_more_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        pos_next        = pos_reg;
        next_ent_next   = next_ent_reg;
        next_vld_next   = next_vld_reg;
        prev_ent_next   = prev_ent_reg;
        prev_vld_next   = prev_vld_reg;
        sh_src_next     = sh_src_reg;
        sh_end_next     = sh_end_reg;
        sh_dist_next    = sh_dist_reg;
        sh_pipe_next    = sh_pipe_reg;
        sh_dst_next     = sh_dst_reg;
        status_next     = status_reg;
        res_pos_next    = res_pos_reg;
        mn_next         = mn_reg;
        mp_next         = mp_reg;

        ram_req         = '0;
        res_valid       = 1'b0;
        res             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    nstart_next   = fecl_pkg::START_W'(in_start);
                    nsize_next    = fecl_pkg::SIZE_W'(in_size);
                    status_next   = fecl_pkg::ST_OK;
                    res_pos_next  = '0;
                    mn_next       = 1'b0;
                    mp_next       = 1'b0;
                    cnt_fin_next  = count_reg;
                    rd_valid_next = 1'b0;
                    next_vld_next = 1'b0;
                    prev_vld_next = 1'b0;
                    sh_pipe_next  = 1'b0;
                    state_next    = S_DONE;
                    case (in_op)
                        fecl_pkg::OP_INSERT:
                        begin
                            if (count_reg == fecl_pkg::CNT_W'(fecl_pkg::DEPTH))
                            begin
                                status_next = fecl_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_MERGE;
                            end
                            else
                            begin
                                issue_idx_next  = fecl_pkg::ADDR_W'(count_reg
                                                  - fecl_pkg::CNT_W'(1));
                                issue_more_next = 1'b1;
                                state_next      = S_SCAN;
                            end
                        end
                        fecl_pkg::OP_UPDATE:
                        begin
                            if (slot_ok)
                            begin
                                ram_req.wr_en         = 1'b1;
                                ram_req.wr_addr       = fecl_pkg::ADDR_W'(in_slot);
                                ram_req.wr_data.start = fecl_pkg::START_W'(in_start);
                                ram_req.wr_data.size  = fecl_pkg::SIZE_W'(in_size);
                            end
                            else
                            begin
                                status_next = fecl_pkg::ST_BAD_IDX;
                            end
                        end
                        fecl_pkg::OP_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                if (!slot_ok)
                                begin
                                    status_next = fecl_pkg::ST_BAD_IDX;
                                end
                                else
                                begin
                                    cnt_fin_next = count_reg - fecl_pkg::CNT_W'(1);
                                    sh_src_next  = fecl_pkg::CNT_W'(in_slot)
                                                 + fecl_pkg::CNT_W'(1);
                                    sh_end_next  = count_reg;
                                    sh_dist_next = 2'd1;
                                    if (fecl_pkg::CNT_W'(in_slot) + fecl_pkg::CNT_W'(1)
                                        < count_reg)
                                    begin
                                        state_next = S_SHIFT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_next = fecl_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // walk down from the top, moving each entry whose start is not below the new one up by one
                if (issue_more_reg)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = issue_idx_reg;
                    rd_valid_next   = 1'b1;
                    rd_idx_next     = issue_idx_reg;
                    issue_more_next = (issue_idx_reg != '0);
                    issue_idx_next  = issue_idx_reg - fecl_pkg::ADDR_W'(1);
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
                if (rd_valid_reg)
                begin
                    if (ram_rd_data.start >= nstart_reg)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = rd_idx_reg + fecl_pkg::ADDR_W'(1);
                        ram_req.wr_data = ram_rd_data;
                        next_ent_next   = ram_rd_data;
                        next_vld_next   = 1'b1;
                        if (rd_idx_reg == '0)
                        begin
                            pos_next        = '0;
                            issue_more_next = 1'b0;
                            state_next      = S_MERGE;
                        end
                    end
                    else
                    begin
                        pos_next        = rd_idx_reg + fecl_pkg::ADDR_W'(1);
                        prev_ent_next   = ram_rd_data;
                        prev_vld_next   = 1'b1;
                        issue_more_next = 1'b0;
                        state_next      = S_MERGE;
                    end
                end
            end

            S_MERGE:
            begin
                // next merge first, then previous on the possibly grown size
                ram_req.wr_en = 1'b1;
                if (mp)
                begin
                    ram_req.wr_addr       = pos_reg - fecl_pkg::ADDR_W'(1);
                    ram_req.wr_data.start = prev_ent_reg.start;
                    ram_req.wr_data.size  = sum_p[fecl_pkg::SIZE_W-1:0];
                    res_pos_next          = pos_reg - fecl_pkg::ADDR_W'(1);
                end
                else
                begin
                    ram_req.wr_addr       = pos_reg;
                    ram_req.wr_data.start = nstart_reg;
                    ram_req.wr_data.size  = cur_size;
                    res_pos_next          = pos_reg;
                end
                if ((touch_next && !mn) || (touch_prev && !mp))
                begin
                    status_next = fecl_pkg::ST_SIZE_OVF;
                end
                mn_next      = mn;
                mp_next      = mp;
                cnt_fin_next = count_plus - fecl_pkg::CNT_W'(drop_n);
                sh_src_next  = merge_src;
                sh_end_next  = count_plus;
                sh_dist_next = drop_n;
                sh_pipe_next = 1'b0;
                if ((drop_n != 2'd0) && (merge_src < count_plus))
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // reads run ahead, writes trail by the drop distance
                if (sh_issue)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = sh_src_reg[fecl_pkg::ADDR_W-1:0];
                    sh_pipe_next    = 1'b1;
                    sh_dst_next     = fecl_pkg::ADDR_W'(sh_src_reg
                                      - fecl_pkg::CNT_W'(sh_dist_reg));
                    sh_src_next     = sh_src_reg + fecl_pkg::CNT_W'(1);
                end
                else
                begin
                    sh_pipe_next = 1'b0;
                    state_next   = S_DONE;
                end
                if (sh_pipe_reg)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = sh_dst_reg;
                    ram_req.wr_data = ram_rd_data;
                end
            end

            S_DONE:
            begin
                res_valid       = 1'b1;
                res.status      = status_reg;
                res.position    = fecl_pkg::POS_W'(res_pos_reg);
                res.entry_count = fecl_pkg::ENTRY_CNT_W'(cnt_fin_reg);
                res.merged_next = mn_reg;
                res.merged_prev = mp_reg;
                if (res_ready)
                begin
                    count_next = cnt_fin_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_more_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            sh_pipe_reg    <= 1'b0;
            next_vld_reg   <= 1'b0;
            prev_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_more_reg <= issue_more_next;
            rd_valid_reg   <= rd_valid_next;
            sh_pipe_reg    <= sh_pipe_next;
            next_vld_reg   <= next_vld_next;
            prev_vld_reg   <= prev_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_fin_reg   <= cnt_fin_next;
        nstart_reg    <= nstart_next;
        nsize_reg     <= nsize_next;
        issue_idx_reg <= issue_idx_next;
        rd_idx_reg    <= rd_idx_next;
        pos_reg       <= pos_next;
        next_ent_reg  <= next_ent_next;
        prev_ent_reg  <= prev_ent_next;
        sh_src_reg    <= sh_src_next;
        sh_end_reg    <= sh_end_next;
        sh_dist_reg   <= sh_dist_next;
        sh_dst_reg    <= sh_dst_next;
        status_reg    <= status_next;
        res_pos_reg   <= res_pos_next;
        mn_reg        <= mn_next;
        mp_reg        <= mp_next;
    end

    `FECL_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= fecl_pkg::CNT_W'(fecl_pkg::DEPTH))
    `FECL_ASSERT_IMPL(a_scan_order,
        (state_reg == S_SCAN) && ram_req.wr_en && ram_req.rd_en,
        ram_req.wr_addr > ram_req.rd_addr)
    `FECL_ASSERT_IMPL(a_shift_order,
        (state_reg == S_SHIFT) && ram_req.wr_en && ram_req.rd_en,
        ram_req.wr_addr < ram_req.rd_addr)
    `FECL_ASSERT_NEXT(a_count_hold, state_reg != S_DONE, count_reg == $past(count_reg))

endmodule

`default_nettype wire

### rtl/fecl_out.sv
// ----------------------------------------------------------------------------
// fecl_out
// result register between the sequencer and the master stream
// ----------------------------------------------------------------------------
`default_nettype none

module fecl_out (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                res_valid,
    output logic                                     res_ready,
    input  wire fecl_pkg::res_t                      res,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [fecl_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    logic           out_valid_reg, out_valid_next;
    fecl_pkg::res_t out_data_reg;

    // take a new result when empty or when the held one leaves this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fecl_pkg::OUT_TDATA_W - fecl_pkg::RES_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

### rtl/free_extent_coalescing_list_top.sv
// ----------------------------------------------------------------------------
// free_extent_coalescing_list_top
// address-ordered free extent table with coalescing on insert
//
//   channel   dir   fields
//   s_*       in    tuser: op; tdata: extent_start, extent_size, slot
//   m_*       out   tdata: status, position, entry_count, merged_next,
//                   merged_prev
//
// insert reads the entries from the top down to its position and moves each up by
// one, then after a merge moves the entries behind it down; remove moves the
// entries above the slot down by one; update and rejected ops need no table walk.
// the single table ram bounds the pace: one read and one write a cycle.
// reset clears the entry count and control state; table contents stay undefined, no sweep.
// a new transfer is taken while the previous result waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module free_extent_coalescing_list_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] extent_start, [39:32] extent_size, [47:40] slot
    input  wire logic [fecl_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  wire logic [fecl_pkg::OP_W-1:0]           s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] status, [9:2] position, [18:10] entry_count, [19] merged_next,
    // [20] merged_prev, [23:21] zero
    output logic [fecl_pkg::OUT_TDATA_W-1:0]         m_tdata
);

    localparam int SIZE_LO = fecl_pkg::START_FIELD_W;
    localparam int SLOT_LO = SIZE_LO + fecl_pkg::SIZE_FIELD_W;

    logic [fecl_pkg::START_FIELD_W-1:0] in_start;
    logic [fecl_pkg::SIZE_FIELD_W-1:0]  in_size;
    logic [fecl_pkg::SLOT_W-1:0]        in_slot;
    fecl_pkg::ram_req_t                 ram_req;
    fecl_pkg::entry_t                   ram_rd_data;
    logic                               res_valid;
    logic                               res_ready;
    fecl_pkg::res_t                     res;

    assign in_start = s_tdata[fecl_pkg::START_FIELD_W-1:0];
    assign in_size  = s_tdata[SLOT_LO-1:SIZE_LO];
    assign in_slot  = s_tdata[SLOT_LO+fecl_pkg::SLOT_W-1:SLOT_LO];

    fecl_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_start    (in_start),
        .in_size     (in_size),
        .in_slot     (in_slot),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    fecl_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    fecl_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
